@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// assert_macros
// assertion helpers for the rtl files, included by the allocator core
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// clocked check, off while reset is asserted
`define BBA_ASSERT(name, prop) \
    name: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("bba assertion failed");

// clocked check that also holds during reset
`define BBA_ASSERT_ALWAYS(name, prop) \
    name: assert property (@(posedge clk) prop) \
        else $error("bba assertion failed");

`endif

@@ src/bba_pkg.sv @@
// ----------------------------------------------------------------------------
// bba_pkg
// types, constants and helpers of the buddy block allocator
// ----------------------------------------------------------------------------
package bba_pkg;

    localparam int MIN_UNIT_LOG2 = 4;
    localparam int MAX_LEVELS    = 13;
    localparam int POOL_UNITS    = 4096;
    localparam int HEADER_BYTES  = 24;

    localparam int UNIT_W  = $clog2(POOL_UNITS);
    localparam int LVL_W   = 4;
    localparam int BYTES_W = 17;
    localparam int REQ_W   = 16;
    localparam int ADDR_W  = 32;

    localparam logic [1:0] ST_ALLOC = 2'd0;
    localparam logic [1:0] ST_FAIL  = 2'd1;
    localparam logic [1:0] ST_FREED = 2'd2;

    localparam logic FUNC_ALLOC = 1'b0;

    localparam logic [1:0] CFG_POOL_BASE  = 2'd0;
    localparam logic [1:0] CFG_POOL_BYTES = 2'd1;

    typedef logic [UNIT_W-1:0] unit_t;
    typedef logic [LVL_W-1:0]  lvl_t;

    typedef struct packed {
        lvl_t level;
        logic free;
    } meta_t;

    typedef struct packed {
        logic fail;
        lvl_t ideal;
        lvl_t avail;
    } size_t;

    typedef enum logic [3:0] {
        S_INIT,
        S_IDLE,
        S_A_RM,
        S_A_SPLIT,
        S_F_LV,
        S_F_LOOP,
        S_F_CHK,
        S_F_PUSH,
        S_F_P2,
        S_F_P3,
        S_DONE
    } state_t;

    // top level index for a pool size, levels in use minus one
    function automatic lvl_t top_level(input logic [BYTES_W-1:0] bytes);
        logic [4:0] lg;
        logic [4:0] n;
        lg = '0;
        for (int i = 0; i < BYTES_W; i++)
        begin
            if (bytes[i])
                lg = 5'(i);
        end
        if (bytes == '0 || lg < 5'(MIN_UNIT_LOG2))
            n = 5'd0;
        else
            n = lg - 5'(MIN_UNIT_LOG2);
        if (n > 5'(MAX_LEVELS - 1))
            n = 5'(MAX_LEVELS - 1);
        if (n > 5'(UNIT_W))
            n = 5'(UNIT_W);
        return lvl_t'(n);
    endfunction

endpackage

@@ src/bba_size.sv @@
// ----------------------------------------------------------------------------
// bba_size
// request sizing: rounds request plus header to a level and picks the
// lowest non-empty free list at or above it
// ----------------------------------------------------------------------------
module bba_size (
    input  logic [bba_pkg::REQ_W-1:0]   request_bytes,
    input  logic [bba_pkg::BYTES_W-1:0] pool_bytes,
    input  bba_pkg::lvl_t               top,
    input  logic [bba_pkg::MAX_LEVELS-1:0] head_valid,
    output bba_pkg::size_t              size
);
    import bba_pkg::*;

    logic [BYTES_W-1:0]    need;
    logic [BYTES_W-1:0]    need_m1;
    logic [4:0]            bit_len;
    logic                  too_big;
    logic [MAX_LEVELS-1:0] cand;
    logic                  found;

    always_comb
    begin
        need    = BYTES_W'(request_bytes) + BYTES_W'(HEADER_BYTES);
        need_m1 = need - BYTES_W'(1);
        too_big = {1'b0, need} > ({1'b0, pool_bytes} + 18'd1);
        bit_len = '0;
        for (int i = 0; i < BYTES_W; i++)
        begin
            if (need_m1[i])
                bit_len = 5'(i + 1);
        end
        if (bit_len > 5'(MIN_UNIT_LOG2))
            size.ideal = lvl_t'(bit_len - 5'(MIN_UNIT_LOG2));
        else
            size.ideal = '0;

        for (int i = 0; i < MAX_LEVELS; i++)
            cand[i] = head_valid[i] && (lvl_t'(i) >= size.ideal) && (lvl_t'(i) <= top);

        found      = 1'b0;
        size.avail = '0;
        for (int i = MAX_LEVELS - 1; i >= 0; i--)
        begin
            if (cand[i])
            begin
                found      = 1'b1;
                size.avail = lvl_t'(i);
            end
        end
        size.fail = (request_bytes == '0) || too_big || !found;
    end

endmodule

@@ src/buddy_block_allocator_core.sv @@
// ----------------------------------------------------------------------------
// buddy_block_allocator_core
// buddy allocator with per-level lifo free lists kept in block ram
// ----------------------------------------------------------------------------
//  channel | signals                                          | direction
//  in      | in_valid in_ready func request_bytes block_address | into core
//  out     | out_valid out_ready status payload_address         | out of core
//  cfg     | cfg_valid cfg_ready cfg_index cfg_data             | into core
//
//  one item at a time. alloc: head unlink, a split step per level, done; a failed
//  alloc or an out-of-pool free goes to done. free: level fetch, a loop and a
//  check step per merge, a one- or three-step push, done. one access per block ram
//  port per step. reset and pool base or bytes writes rebuild the pool in init. a
//  waiting result blocks only the next item's completion, not its intake.
module buddy_block_allocator_core (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        in_valid,
    output logic                        in_ready,
    input  logic                        func,
    input  logic [bba_pkg::REQ_W-1:0]   request_bytes,
    input  logic [bba_pkg::ADDR_W-1:0]  block_address,
    output logic                        out_valid,
    input  logic                        out_ready,
    output logic [1:0]                  status,
    output logic [bba_pkg::ADDR_W-1:0]  payload_address,
    input  logic                        cfg_valid,
    output logic                        cfg_ready,
    input  logic [1:0]                  cfg_index,
    input  logic [bba_pkg::ADDR_W-1:0]  cfg_data
);
    import bba_pkg::*;
    `include "assert_macros.svh"

    state_t state_reg, state_next;
    logic [MAX_LEVELS-1:0] hv_reg, hv_next;
    unit_t head_reg [MAX_LEVELS];
    unit_t head_next [MAX_LEVELS];
    unit_t unit_reg, unit_next;
    unit_t tail_reg, tail_next;
    lvl_t  lv_reg, lv_next;
    lvl_t  ideal_reg, ideal_next;
    lvl_t  top_reg, top_next;
    logic [ADDR_W-1:0]  base_reg, base_next;
    logic [BYTES_W-1:0] bytes_reg, bytes_next;
    logic [1:0]         rstat_reg, rstat_next;
    logic [ADDR_W-1:0]  raddr_reg, raddr_next;
    logic               out_valid_reg, out_valid_next;
    logic [1:0]         out_status_reg, out_status_next;
    logic [ADDR_W-1:0]  out_addr_reg, out_addr_next;

    // block rams
    meta_t meta_mem [POOL_UNITS];
    unit_t prev_mem [POOL_UNITS];
    unit_t next_mem [POOL_UNITS];
    meta_t meta_q;
    unit_t prev_q, nxt_q;
    logic  meta_we, prev_we, next_we;
    unit_t meta_wa, prev_wa, next_wa;
    meta_t meta_wd;
    unit_t prev_wd, next_wd;
    unit_t meta_ra, prev_ra, next_ra;

    size_t size;
    logic  in_xfer, cfg_xfer;
    logic [ADDR_W-1:0] off;
    unit_t bit_u, buddy;
    lvl_t  lvp;
    logic [MAX_LEVELS-1:0] lvl_mask;

    bba_size u_size (
        .request_bytes (request_bytes),
        .pool_bytes    (bytes_reg),
        .top           (top_reg),
        .head_valid    (hv_reg),
        .size          (size)
    );

    assign in_ready  = (state_reg == S_IDLE) && !cfg_valid;
    assign cfg_ready = (state_reg == S_IDLE);
    assign in_xfer   = in_valid && in_ready;
    assign cfg_xfer  = cfg_valid && cfg_ready;
    assign out_valid       = out_valid_reg;
    assign status          = out_status_reg;
    assign payload_address = out_addr_reg;

    always_ff @(posedge clk)
    begin
        if (meta_we)
            meta_mem[meta_wa] <= meta_wd;
        if (prev_we)
            prev_mem[prev_wa] <= prev_wd;
        if (next_we)
            next_mem[next_wa] <= next_wd;
        meta_q <= meta_mem[meta_ra];
        prev_q <= prev_mem[prev_ra];
        nxt_q  <= next_mem[next_ra];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_INIT;
            hv_reg         <= '0;
            for (int i = 0; i < MAX_LEVELS; i++)
                head_reg[i] <= '0;
            unit_reg       <= '0;
            tail_reg       <= '0;
            lv_reg         <= '0;
            ideal_reg      <= '0;
            top_reg        <= top_level(BYTES_W'(POOL_UNITS << MIN_UNIT_LOG2));
            base_reg       <= '0;
            bytes_reg      <= BYTES_W'(POOL_UNITS << MIN_UNIT_LOG2);
            rstat_reg      <= ST_FAIL;
            raddr_reg      <= '0;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_FAIL;
            out_addr_reg   <= '0;
        end
        else
        begin
            state_reg      <= state_next;
            hv_reg         <= hv_next;
            head_reg       <= head_next;
            unit_reg       <= unit_next;
            tail_reg       <= tail_next;
            lv_reg         <= lv_next;
            ideal_reg      <= ideal_next;
            top_reg        <= top_next;
            base_reg       <= base_next;
            bytes_reg      <= bytes_next;
            rstat_reg      <= rstat_next;
            raddr_reg      <= raddr_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_addr_reg   <= out_addr_next;
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        hv_next         = hv_reg;
        head_next       = head_reg;
        unit_next       = unit_reg;
        tail_next       = tail_reg;
        lv_next         = lv_reg;
        ideal_next      = ideal_reg;
        top_next        = top_reg;
        base_next       = base_reg;
        bytes_next      = bytes_reg;
        rstat_next      = rstat_reg;
        raddr_next      = raddr_reg;
        out_valid_next  = out_valid_reg && !out_ready;
        out_status_next = out_status_reg;
        out_addr_next   = out_addr_reg;

        meta_we = 1'b0;
        prev_we = 1'b0;
        next_we = 1'b0;
        meta_wa = unit_reg;
        prev_wa = unit_reg;
        next_wa = unit_reg;
        meta_wd = '{level: lv_reg, free: 1'b1};
        prev_wd = unit_reg;
        next_wd = unit_reg;
        meta_ra = unit_reg;
        prev_ra = unit_reg;
        next_ra = unit_reg;

        off   = block_address - base_reg - ADDR_W'(HEADER_BYTES);
        bit_u = unit_t'(1) << lv_reg;
        buddy = unit_reg ^ bit_u;
        lvp   = (lv_reg > top_reg) ? top_reg : lv_reg;

        case (state_reg)
            S_INIT:
            begin
                meta_we = 1'b1;
                prev_we = 1'b1;
                next_we = 1'b1;
                meta_wa = '0;
                prev_wa = '0;
                next_wa = '0;
                meta_wd = '{level: top_reg, free: 1'b1};
                prev_wd = '0;
                next_wd = '0;
                hv_next = '0;
                hv_next[top_reg] = 1'b1;
                for (int i = 0; i < MAX_LEVELS; i++)
                    head_next[i] = '0;
                state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (cfg_xfer)
                begin
                    if (cfg_index == CFG_POOL_BASE)
                    begin
                        base_next  = cfg_data;
                        state_next = S_INIT;
                    end
                    else if (cfg_index == CFG_POOL_BYTES)
                    begin
                        bytes_next = cfg_data[BYTES_W-1:0];
                        top_next   = top_level(cfg_data[BYTES_W-1:0]);
                        state_next = S_INIT;
                    end
                end
                else if (in_xfer)
                begin
                    raddr_next = '0;
                    if (func == FUNC_ALLOC)
                    begin
                        rstat_next = ST_FAIL;
                        if (size.fail)
                            state_next = S_DONE;
                        else
                        begin
                            unit_next  = head_reg[size.avail];
                            lv_next    = size.avail;
                            ideal_next = size.ideal;
                            prev_ra    = head_reg[size.avail];
                            next_ra    = head_reg[size.avail];
                            state_next = S_A_RM;
                        end
                    end
                    else
                    begin
                        rstat_next = ST_FREED;
                        unit_next  = off[MIN_UNIT_LOG2 +: UNIT_W];
                        meta_ra    = off[MIN_UNIT_LOG2 +: UNIT_W];
                        if (off[ADDR_W-1:MIN_UNIT_LOG2+UNIT_W] != '0)
                            state_next = S_DONE;
                        else
                            state_next = S_F_LV;
                    end
                end
            end
            S_A_RM:
            begin
                // unlink the head block of the chosen level
                if (nxt_q == unit_reg)
                begin
                    hv_next[lv_reg]   = 1'b0;
                    head_next[lv_reg] = '0;
                end
                else
                begin
                    next_we = 1'b1;
                    next_wa = prev_q;
                    next_wd = nxt_q;
                    prev_we = 1'b1;
                    prev_wa = nxt_q;
                    prev_wd = prev_q;
                    head_next[lv_reg] = nxt_q;
                end
                state_next = S_A_SPLIT;
            end
            S_A_SPLIT:
            begin
                if (lv_reg > ideal_reg)
                begin
                    // lists from the ideal level up to the chosen one are empty, so the push is trivial
                    bit_u   = unit_t'(1) << (lv_reg - lvl_t'(1));
                    buddy   = unit_reg ^ bit_u;
                    meta_we = 1'b1;
                    meta_wa = buddy;
                    meta_wd = '{level: lv_reg - lvl_t'(1), free: 1'b1};
                    prev_we = 1'b1;
                    prev_wa = buddy;
                    prev_wd = buddy;
                    next_we = 1'b1;
                    next_wa = buddy;
                    next_wd = buddy;
                    hv_next[lv_reg - lvl_t'(1)]   = 1'b1;
                    head_next[lv_reg - lvl_t'(1)] = buddy;
                    lv_next = lv_reg - lvl_t'(1);
                end
                else
                begin
                    meta_we    = 1'b1;
                    meta_wa    = unit_reg;
                    meta_wd    = '{level: ideal_reg, free: 1'b0};
                    rstat_next = ST_ALLOC;
                    raddr_next = base_reg
                               + ADDR_W'({unit_reg, {MIN_UNIT_LOG2{1'b0}}})
                               + ADDR_W'(HEADER_BYTES);
                    state_next = S_DONE;
                end
            end
            S_F_LV:
            begin
                meta_we    = 1'b1;
                meta_wa    = unit_reg;
                meta_wd    = '{level: meta_q.level, free: 1'b1};
                lv_next    = meta_q.level;
                state_next = S_F_LOOP;
            end
            S_F_LOOP:
            begin
                if (lv_reg < top_reg)
                begin
                    meta_ra    = buddy;
                    prev_ra    = buddy;
                    next_ra    = buddy;
                    state_next = S_F_CHK;
                end
                else
                    state_next = S_F_PUSH;
            end
            S_F_CHK:
            begin
                if (meta_q.level == lv_reg && meta_q.free)
                begin
                    // take the buddy off its list and merge
                    if (nxt_q == buddy)
                    begin
                        hv_next[lv_reg]   = 1'b0;
                        head_next[lv_reg] = '0;
                    end
                    else
                    begin
                        next_we = 1'b1;
                        next_wa = prev_q;
                        next_wd = nxt_q;
                        prev_we = 1'b1;
                        prev_wa = nxt_q;
                        prev_wd = prev_q;
                        if (head_reg[lv_reg] == buddy)
                            head_next[lv_reg] = nxt_q;
                    end
                    unit_next  = unit_reg & ~bit_u;
                    meta_we    = 1'b1;
                    meta_wa    = unit_reg & ~bit_u;
                    meta_wd    = '{level: lv_reg + lvl_t'(1), free: 1'b1};
                    lv_next    = lv_reg + lvl_t'(1);
                    state_next = S_F_LOOP;
                end
                else
                    state_next = S_F_PUSH;
            end
            S_F_PUSH:
            begin
                meta_we = 1'b1;
                meta_wa = unit_reg;
                meta_wd = '{level: lvp, free: 1'b1};
                lv_next = lvp;
                head_next[lvp] = unit_reg;
                hv_next[lvp]   = 1'b1;
                if (!hv_reg[lvp])
                begin
                    prev_we    = 1'b1;
                    next_we    = 1'b1;
                    state_next = S_DONE;
                end
                else
                begin
                    // fetch the tail through the old head
                    head_next[lvp] = head_reg[lvp];
                    prev_ra        = head_reg[lvp];
                    state_next     = S_F_P2;
                end
            end
            S_F_P2:
            begin
                tail_next  = prev_q;
                next_we    = 1'b1;
                next_wd    = head_reg[lv_reg];
                prev_we    = 1'b1;
                prev_wd    = prev_q;
                state_next = S_F_P3;
            end
            S_F_P3:
            begin
                prev_we = 1'b1;
                prev_wa = head_reg[lv_reg];
                prev_wd = unit_reg;
                next_we = 1'b1;
                next_wa = tail_reg;
                next_wd = unit_reg;
                head_next[lv_reg] = unit_reg;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || out_ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = rstat_reg;
                    out_addr_next   = raddr_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        for (int i = 0; i < MAX_LEVELS; i++)
            lvl_mask[i] = (lvl_t'(i) <= top_reg);
    end

    // no free list above the top level holds a block once the pool is built
    `BBA_ASSERT(a_hv_in_range, state_reg != S_INIT |-> (hv_reg & ~lvl_mask) == '0)
    // failures and frees return a zero address
    `BBA_ASSERT(a_zero_addr, out_valid && status != ST_ALLOC |-> payload_address == '0)
    // an accepted item keeps the input closed on the next cycle
    `BBA_ASSERT(a_busy_after_xfer, in_xfer |=> !in_ready)
    // a pool base or pool bytes register write rebuilds the pool
    `BBA_ASSERT(a_cfg_init, cfg_xfer && (cfg_index == CFG_POOL_BASE ||
        cfg_index == CFG_POOL_BYTES) |=> state_reg == S_INIT)

endmodule
